>>> rtl/sldf_pkg.sv
// Shared types and constants for the sync/length/checksum frame receiver.
`timescale 1ns / 1ps

package sldf_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAB;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SUM_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LEN_ERR = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic                take_len;    // store length byte, start sum
    logic                take_body;   // store data byte, add to sum
    logic                start_emit;  // rewind read index
    logic                rd_issue;    // read store at read index
    logic                load_data;   // load read data into output word
    logic                load_err;    // load error word into output
    logic [STATUS_W-1:0] err_status;  // error code for load_err
  } sldf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sync1_hit;  // input byte equals first sync
    logic sync2_hit;  // input byte equals second sync
    logic len_bad;    // input byte is not a usable length
    logic body_done;  // all length and data bytes stored
    logic sum_ok;     // input byte equals running sum
    logic rd_last;    // word being loaded is the final frame byte
    logic out_stall;  // output word held and not taken this cycle
  } sldf_stat_t;

endpackage

>>> rtl/sldf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module sldf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sldf_dpath.sv
// Datapath: sync registers, frame store, running sum, output word register.
`timescale 1ns / 1ps

module sldf_dpath #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sldf_pkg::BYTE_W-1:0]         cfg_wdata,
  input  logic [sldf_pkg::BYTE_W-1:0]         rx_byte,
  input  sldf_pkg::sldf_cmd_t                 cmd,
  output sldf_pkg::sldf_stat_t                stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sldf_pkg::BYTE_W-1:0]         out_byte,
  output logic [sldf_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last
);

  import sldf_pkg::*;

  localparam int                AW      = $clog2(BUFFER_DEPTH);
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(BUFFER_DEPTH - 1);

  logic [BYTE_W-1:0]   sync_first_r, sync_second_r;
  logic [AW-1:0]       fill_r, fill_nxt;
  logic [AW-1:0]       len_r, len_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_rdata;
  logic                rd_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame store
  assign ram_we    = cmd.take_len | cmd.take_body;
  assign ram_waddr = cmd.take_len ? '0 : fill_r;

  sldf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_last = ((rd_idx_r + AW'(1)) == len_r);

  // Fill index, length, running sum and read index
  always_comb begin
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.take_len) begin
      len_nxt  = rx_byte[AW-1:0];
      fill_nxt = AW'(1);
      sum_nxt  = rx_byte;
    end else if (cmd.take_body) begin
      fill_nxt = fill_r + AW'(1);
      sum_nxt  = sum_r + rx_byte;
    end
    if (cmd.start_emit) begin
      rd_idx_nxt = '0;
    end else if (cmd.load_data) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    fill_r   <= fill_nxt;
    len_r    <= len_nxt;
    sum_r    <= sum_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  // Output word register: load on command, drop when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.load_data) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = ram_rdata;
      out_status_nxt = STAT_OK;
      out_last_nxt   = rd_last;
    end else if (cmd.load_err) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = '0;
      out_status_nxt = cmd.err_status;
      out_last_nxt   = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Status to controller
  always_comb begin
    stat.sync1_hit = (rx_byte == sync_first_r);
    stat.sync2_hit = (rx_byte == sync_second_r);
    stat.len_bad   = (rx_byte == '0) || (rx_byte > MAX_LEN);
    stat.body_done = (fill_r == len_r);
    stat.sum_ok    = (rx_byte == sum_r);
    stat.rd_last   = rd_last;
    stat.out_stall = out_valid_r & ~out_tready;
  end

endmodule

>>> rtl/sldf_ctrl.sv
// Controller: hunt, length, body and emit sequencing.
`timescale 1ns / 1ps

module sldf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  sldf_pkg::sldf_stat_t stat,
  output sldf_pkg::sldf_cmd_t  cmd
);

  import sldf_pkg::*;

  typedef enum logic [5:0] {
    ST_SYNC1 = 6'b000001,
    ST_SYNC2 = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_BODY  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_LD    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  // Accept words only in input states; hold the length word and the
  // checksum word while the output word is stalled
  always_comb begin
    case (state_r)
      ST_SYNC1, ST_SYNC2: in_tready = 1'b1;
      ST_LEN:             in_tready = ~stat.out_stall;
      ST_BODY:            in_tready = ~(stat.body_done & stat.out_stall);
      default:            in_tready = 1'b0;
    endcase
  end

  assign in_acc = in_tvalid & in_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_SYNC1: begin
        if (in_acc && stat.sync1_hit) begin
          state_nxt = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (in_acc) begin
          state_nxt = stat.sync2_hit ? ST_LEN : ST_SYNC1;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          if (stat.len_bad) begin
            cmd.load_err   = 1'b1;
            cmd.err_status = STAT_LEN_ERR;
            state_nxt      = ST_SYNC1;
          end else begin
            cmd.take_len = 1'b1;
            state_nxt    = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (in_acc) begin
          if (!stat.body_done) begin
            cmd.take_body = 1'b1;
          end else if (stat.sum_ok) begin
            cmd.start_emit = 1'b1;
            state_nxt      = ST_RD;
          end else begin
            cmd.load_err   = 1'b1;
            cmd.err_status = STAT_SUM_ERR;
            state_nxt      = ST_SYNC1;
          end
        end
      end
      ST_RD: begin
        // read once the output word is free by the next edge
        if (!stat.out_stall) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_LD;
        end
      end
      ST_LD: begin
        cmd.load_data = 1'b1;
        state_nxt     = stat.rd_last ? ST_SYNC1 : ST_RD;
      end
      default: begin
        state_nxt = ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sync_length_checksum_deframer_core.sv
// Top level of the two-byte sync, length and 8-bit sum frame receiver.
//
//   channel  direction  handshake               payload
//   in_      input      in_tvalid/in_tready     in_tdata[7:0] = rx_byte
//   out_     output     out_tvalid/out_tready   out_tdata[7:0] = out_byte,
//                                               out_tuser[1:0] = status,
//                                               out_tlast = last
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// The checksum word is checked in the cycle it is taken. A good frame of L
// bytes is then emitted word by word: a registered read of the frame store,
// issued once the output word is free, then an output load. No input is taken
// while it drains.
// Reset (rst_n, synchronous) returns to hunting for the first sync byte.
// A stalled output word holds off the length word and the checksum word.
`timescale 1ns / 1ps

module sync_length_checksum_deframer_core #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,    // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,   // [7:0] out_byte
  output logic [1:0]                          out_tuser,   // [1:0] status
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sldf_pkg::BYTE_W-1:0]         cfg_wdata
);

  import sldf_pkg::*;

  sldf_cmd_t  cmd;
  sldf_stat_t stat;

  sldf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sldf_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

>>> bench/sldf_frame_checker.sv
// Frame receiver checker: tracks the byte stream, predicts output words and compares them.
`timescale 1ns / 1ps

module sldf_frame_checker #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] rx_byte
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,   // [7:0] out_byte
  input  logic [1:0]                     out_tuser,   // [1:0] status
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sldf_pkg::BYTE_W-1:0]    cfg_wdata,
  output int                             mismatch_count,
  output int                             words_due
);

  import sldf_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);

  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    WANT_LEN,
    COLLECT
  } hunt_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic                last;
  } frame_word_t;

  hunt_t             phase;
  logic [6:0]        fill_cnt;
  logic [5:0]        frame_len;
  logic [7:0]        frame_bytes [BUFFER_DEPTH];
  logic [7:0]        sync1;
  logic [7:0]        sync2;
  frame_word_t       due_q[$];
  int                errs;

  function automatic frame_word_t make_word(logic [7:0] d, logic [1:0] st, logic lst);
    frame_word_t w;
    w.data   = d;
    w.status = st;
    w.last   = lst;
    return w;
  endfunction

  // Advance the frame parser by one received byte, queue any words it releases
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0] sum;
    sum = 8'h00;
    case (phase)
      SEEK_FIRST: begin
        if (b == sync1) phase = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        phase = (b == sync2) ? WANT_LEN : SEEK_FIRST;
      end
      WANT_LEN: begin
        if (b == 8'h00 || b > BUFFER_DEPTH - 1) begin
          due_q.push_back(make_word(8'h00, STAT_LEN_ERR, 1'b1));
          phase = SEEK_FIRST;
        end else begin
          frame_len      = b[5:0];
          frame_bytes[0] = b;
          fill_cnt       = 7'd1;
          phase          = COLLECT;
        end
      end
      default: begin
        if (fill_cnt < frame_len) begin
          frame_bytes[fill_cnt[IW-1:0]] = b;
          fill_cnt = fill_cnt + 7'd1;
        end else begin
          // This byte is the checksum: compare, then release the frame or one error
          phase = SEEK_FIRST;
          for (int j = 0; j < frame_len; j++) sum = sum + frame_bytes[j[IW-1:0]];
          if (sum != b) begin
            due_q.push_back(make_word(8'h00, STAT_SUM_ERR, 1'b1));
          end else begin
            for (int j = 0; j < frame_len; j++)
              due_q.push_back(make_word(frame_bytes[j[IW-1:0]], STAT_OK,
                                        (j == frame_len - 1)));
          end
        end
      end
    endcase
  endtask

  // Track registers and input, then check each output word against the oldest prediction
  always @(posedge clk) begin
    frame_word_t exp_w;
    if (!rst_n) begin
      phase     = SEEK_FIRST;
      fill_cnt  = 7'd0;
      frame_len = 6'd0;
      sync1     = SYNC_FIRST_RST;
      sync2     = SYNC_SECOND_RST;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync1 = cfg_wdata;
          REG_SYNC_SECOND: sync2 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) absorb_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected word: data=%h status=%0d last=%0b",
                     $realtime, out_tdata, out_tuser, out_tlast);
        end else begin
          exp_w = due_q.pop_front();
          if (out_tdata !== exp_w.data || out_tuser !== exp_w.status ||
              out_tlast !== exp_w.last) begin
            errs++;
            if (errs <= 10)
              $display("%0t: word mismatch: exp data=%h status=%0d last=%0b,",
                       $realtime, exp_w.data, exp_w.status, exp_w.last,
                       " got data=%h status=%0d last=%0b",
                       out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
    words_due      <= due_q.size();
    mismatch_count <= errs;
  end

  initial errs = 0;

endmodule

>>> bench/tb_top.sv
// Testbench top: drives framed byte streams and register writes, gives the verdict.
`timescale 1ns / 1ps

module tb_top;

  import sldf_pkg::*;

  localparam int DEPTH      = 64;
  localparam int MAX_LEN    = DEPTH - 1;
  localparam int CYCLE_CAP  = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_FIRST;
  logic [BYTE_W-1:0]    cfg_wdata = 8'h00;

  int   mismatch_count;
  int   words_due;
  int   cycles = 0;
  int   frame_bytes_sent = 0;
  int   send_idle_pct = 15;
  bit   calm = 1'b0;
  int   stall_left = 0;
  int   ready_run = 0;
  logic [7:0] cur_first = SYNC_FIRST_RST;
  logic [7:0] cur_second = SYNC_SECOND_RST;

  sync_length_checksum_deframer_core #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sldf_frame_checker #(.BUFFER_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .words_due(words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Output backpressure: random stall bursts, free-running stretches, none when calm
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (calm || ready_run > 0) begin
      out_tready <= 1'b1;
      if (ready_run > 0) ready_run <= ready_run - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (r < 20) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 17) - 1;
    end else if (r < 28) begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(20, 80);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word, with an optional idle burst first; hold valid until taken
  task automatic send_word(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Header, length, body and checksum; unusable lengths stop after the length word
  task automatic send_frame(input logic [7:0] len_byte, input bit bad_sum, input int cut);
    logic [7:0] sum;
    logic [7:0] d;
    int         body;
    send_word(cur_first);
    send_word(cur_second);
    send_word(len_byte);
    frame_bytes_sent += 3;
    if (len_byte != 8'h00 && len_byte <= MAX_LEN) begin
      sum  = len_byte;
      body = len_byte - 1;
      if (cut > 0 && cut < body) body = cut;
      for (int i = 0; i < body; i++) begin
        d = pick_data();
        sum = sum + d;
        send_word(d);
      end
      frame_bytes_sent += body;
      if (cut == 0) begin
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        send_word(sum);
        frame_bytes_sent++;
      end
    end
  endtask

  // Hold input until every predicted word has left, then let the pipeline settle
  task automatic wait_until_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_syncs(input logic [7:0] first_val, input logic [7:0] second_val);
    wait_until_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_wdata <= first_val;
    @(posedge clk);
    cfg_index <= REG_SYNC_SECOND;
    cfg_wdata <= second_val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_first  = first_val;
    cur_second = second_val;
  endtask

  // Mostly well-formed frames with random content, plus bad sums, bad lengths, truncated frames and noise
  task automatic random_traffic(input int n_bytes);
    int   stop_at;
    int   r;
    int   len;
    stop_at = frame_bytes_sent + n_bytes;
    while (frame_bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 5)       len = MAX_LEN;
      else if ($urandom_range(0, 99) < 12) len = $urandom_range(9, MAX_LEN - 1);
      else                                 len = $urandom_range(1, 8);
      if (r < 68) begin
        send_frame(8'(len), 1'b0, 0);
      end else if (r < 78) begin
        send_frame(8'(len), 1'b1, 0);
      end else if (r < 86) begin
        if ($urandom_range(0, 1)) send_frame(8'h00, 1'b0, 0);
        else send_frame(8'($urandom_range(DEPTH, 255)), 1'b0, 0);
      end else if (r < 90) begin
        send_frame(8'($urandom_range(4, 12)), 1'b0, $urandom_range(1, 2));
      end else begin
        // Noise, sometimes a broken header
        if ($urandom_range(0, 1)) send_word(cur_first);
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: length one, zero and long lengths, wrong second sync, zero data, bad sum
    send_word(SYNC_FIRST_RST); send_word(SYNC_SECOND_RST);
    send_word(8'h01); send_word(8'h01);
    send_frame(8'h00, 1'b0, 0);
    send_frame(8'(DEPTH), 1'b0, 0);
    send_frame(8'hFF, 1'b0, 0);
    send_word(SYNC_FIRST_RST); send_word(SYNC_FIRST_RST); send_word(SYNC_SECOND_RST);
    send_word(SYNC_FIRST_RST); send_word(SYNC_SECOND_RST);
    send_word(8'h02); send_word(8'h00); send_word(8'h02);
    send_frame(8'h01, 1'b1, 0);

    random_traffic(110);

    send_idle_pct = 30;
    write_syncs(8'h00, 8'hFF);
    random_traffic(110);

    send_idle_pct = 0;
    write_syncs(8'hFF, 8'h00);
    random_traffic(90);

    // Equal sync bytes
    send_idle_pct = 10;
    write_syncs(8'h5A, 8'h5A);
    random_traffic(80);

    write_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(30);
    calm = 1'b1;
    random_traffic(60);

    wait_until_quiet();
    if (mismatch_count == 0 && words_due == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sldf_pkg.sv
rtl/sldf_ram.sv
rtl/sldf_dpath.sv
rtl/sldf_ctrl.sv
rtl/sync_length_checksum_deframer_core.sv
bench/sldf_frame_checker.sv
bench/tb_top.sv
